// File: rtl/bpis_pkg.sv
// Shared types and constants for the blocked positional insert store.
// No dependencies.
`default_nettype none
package bpis_pkg;
   localparam int unsigned POS_W = 9;
   localparam int unsigned OUT_W = 32;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_POS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   localparam logic REQ_READ   = 1'b0;
   localparam logic REQ_INSERT = 1'b1;
endpackage
`default_nettype wire

// File: rtl/bpis_if.sv
// Valid/ready channel carrying a payload struct.
// Depends on nothing; payload type is given by the instantiating code.
`default_nettype none
interface bpis_if #(parameter type payload_type = logic) (input wire logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/bpis_ram.sv
// Single-port-write, one-read synchronous memory with a registered read port.
// Depends on nothing.
`default_nettype none
module bpis_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW = 8
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/blocked_positional_insert_store.sv
// Top level: block directory, sequencer and element memory.
// Depends on bpis_pkg, bpis_ram.
//
//   channel | dir | beat contents
//   req     | in  | req_type, position, value
//   rsp     | out | read_data, status, total_after
//
// One request is in flight at a time. A read walks the directory one block per
// cycle. An insert adds one memory read-modify-write per shifted element (up to
// BLOCK_LIMIT), and a split adds one more per moved element plus a relink step.
// Reset is synchronous and clears the directory at once; the element memory needs
// no clearing. A stalled response holds in its output register; req is taken
// again once it drains.
`default_nettype none
module blocked_positional_insert_store #(
   parameter int unsigned BLOCK_LIMIT = 15,
   parameter int unsigned MAX_BLOCKS  = 16,
   parameter int unsigned DATA_WIDTH  = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic                     req_req_type,
   input  wire logic [bpis_pkg::POS_W-1:0] req_position,
   input  wire logic signed [31:0]       req_value,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic signed [31:0]            rsp_read_data,
   output logic [1:0]                    rsp_status,
   output logic [bpis_pkg::POS_W-1:0]    rsp_total_after
);
   import bpis_pkg::*;

   localparam int unsigned SLOTS  = BLOCK_LIMIT + 1;
   localparam int unsigned SW     = $clog2(SLOTS + 1);   // holds a length up to SLOTS
   localparam int unsigned OW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned BW     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CW     = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned TW     = $clog2(MAX_BLOCKS * SLOTS + 1) + 1;
   localparam int unsigned AW     = BW + OW;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_SPLIT_RD, S_SPLIT_WR, S_SPLIT_FIX,
      S_SHIFT_RD, S_SHIFT_WR, S_PUT, S_RD_WAIT, S_RD_TAKE, S_RESP
   } state_type;

   state_type              state_ff;
   logic [SW-1:0]          len_ff   [MAX_BLOCKS];
   logic [BW-1:0]          order_ff [MAX_BLOCKS];
   logic [CW-1:0]          used_ff;
   logic [TW-1:0]          total_ff;
   logic                   op_ff;
   logic [POS_W-1:0]       pos_ff;
   logic [DATA_WIDTH-1:0]  val_ff;
   logic [CW-1:0]          j_ff;       // logical block walk index
   logic [TW-1:0]          cum_ff;
   logic [CW-1:0]          lb_ff;
   logic [SW-1:0]          off_ff;
   logic [SW-1:0]          k_ff;
   logic [SW-1:0]          keep_ff;
   logic [BW-1:0]          nb_ff;
   logic [31:0]            rd_ff;
   status_type             st_ff;

   logic                   we;
   logic [AW-1:0]          waddr, raddr;
   logic [DATA_WIDTH-1:0]  wdata, rdata;

   bpis_ram #(.WIDTH(DATA_WIDTH), .DEPTH(1 << AW), .AW(AW)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(waddr), .wr_data(wdata),
      .rd_addr(raddr), .rd_data(rdata)
   );

   logic [BW-1:0] pb;
   logic [SW-1:0] plen, jlen;
   assign pb   = order_ff[lb_ff[BW-1:0]];
   assign plen = len_ff[pb];
   assign jlen = len_ff[order_ff[j_ff[BW-1:0]]];

   function automatic logic [AW-1:0] addr(input logic [BW-1:0] b, input logic [SW-1:0] o);
      return {b, o[OW-1:0]};
   endfunction

   // memory addressing per state
   always_comb begin
      we = 1'b0;
      waddr = addr(pb, k_ff);
      wdata = rdata;
      raddr = addr(pb, k_ff);
      unique case (state_ff)
         S_SPLIT_RD: raddr = addr(pb, SW'(keep_ff + k_ff));
         S_SPLIT_WR: begin
            we = 1'b1; waddr = addr(nb_ff, k_ff);
         end
         S_SHIFT_RD: raddr = addr(pb, SW'(k_ff - 1'b1));
         S_SHIFT_WR: we = 1'b1;
         S_PUT: begin
            we = 1'b1; waddr = addr(pb, off_ff); wdata = val_ff;
         end
         S_RD_WAIT, S_RD_TAKE: raddr = addr(pb, off_ff);
         default: ;
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_read_data = rd_ff;
   assign rsp_status = st_ff;
   assign rsp_total_after = total_ff[POS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < MAX_BLOCKS; i++) begin
            len_ff[i]   <= '0;
            order_ff[i] <= BW'(i);
         end
         used_ff  <= '0;
         total_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               op_ff  <= req_req_type;
               pos_ff <= req_position;
               val_ff <= DATA_WIDTH'(req_value);
               rd_ff  <= '0;
               st_ff  <= STATUS_OK;
               j_ff   <= '0;
               cum_ff <= '0;
               if ((req_req_type == REQ_READ && TW'(req_position) >= total_ff)
                   || (req_req_type == REQ_INSERT && TW'(req_position) > total_ff)
                   || (used_ff == '0 && req_position != '0)) begin
                  st_ff <= STATUS_POS;
                  state_ff <= S_RESP;
               end else if (used_ff == '0) begin
                  lb_ff <= '0; off_ff <= '0; k_ff <= '0;
                  state_ff <= S_PUT;
                  used_ff <= CW'(1);
               end else if (TW'(req_position) >= total_ff) begin
                  lb_ff <= CW'(used_ff - 1'b1);
                  state_ff <= S_DECIDE;
                  off_ff <= len_ff[order_ff[BW'(used_ff - 1'b1)]];
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // walk one block per cycle until the running count passes pos
               if (TW'(pos_ff) < cum_ff + TW'(jlen)) begin
                  lb_ff  <= j_ff;
                  off_ff <= SW'(TW'(pos_ff) - cum_ff);
                  state_ff <= S_DECIDE;
               end else begin
                  cum_ff <= cum_ff + TW'(jlen);
                  j_ff   <= CW'(j_ff + 1'b1);
               end
            end
            S_DECIDE: begin
               if (op_ff == REQ_READ) begin
                  state_ff <= S_RD_WAIT;
               end else if (plen > SW'(BLOCK_LIMIT)) begin
                  if (used_ff >= CW'(MAX_BLOCKS)) begin
                     st_ff <= STATUS_FULL;
                     state_ff <= S_RESP;
                  end else begin
                     nb_ff   <= order_ff[used_ff[BW-1:0]];
                     keep_ff <= plen >> 1;
                     k_ff    <= '0;
                     state_ff <= S_SPLIT_RD;
                  end
               end else begin
                  k_ff <= plen;
                  state_ff <= (plen > off_ff) ? S_SHIFT_RD : S_PUT;
               end
            end
            S_SPLIT_RD: state_ff <= S_SPLIT_WR;
            S_SPLIT_WR: begin
               if (SW'(k_ff + 1'b1) == SW'(plen - keep_ff)) state_ff <= S_SPLIT_FIX;
               else state_ff <= S_SPLIT_RD;
               k_ff <= SW'(k_ff + 1'b1);
            end
            S_SPLIT_FIX: begin
               // link new block after the split one, then re-locate
               len_ff[pb]    <= keep_ff;
               len_ff[nb_ff] <= SW'(plen - keep_ff);
               for (int i = 1; i < MAX_BLOCKS; i++)
                  if (CW'(i) > CW'(lb_ff + 1'b1) && CW'(i) <= used_ff)
                     order_ff[i] <= order_ff[i-1];
               order_ff[BW'(lb_ff + 1'b1)] <= nb_ff;
               used_ff <= CW'(used_ff + 1'b1);
               if (off_ff >= keep_ff) begin
                  lb_ff  <= CW'(lb_ff + 1'b1);
                  off_ff <= SW'(off_ff - keep_ff);
                  k_ff   <= SW'(plen - keep_ff);
                  state_ff <= (SW'(plen - keep_ff) > SW'(off_ff - keep_ff))
                              ? S_SHIFT_RD : S_PUT;
               end else begin
                  k_ff <= keep_ff;
                  state_ff <= (keep_ff > off_ff) ? S_SHIFT_RD : S_PUT;
               end
            end
            S_SHIFT_RD: state_ff <= S_SHIFT_WR;
            S_SHIFT_WR: begin
               k_ff <= SW'(k_ff - 1'b1);
               state_ff <= (SW'(k_ff - 1'b1) > off_ff) ? S_SHIFT_RD : S_PUT;
            end
            S_PUT: begin
               len_ff[pb] <= SW'(plen + 1'b1);
               total_ff <= TW'(total_ff + 1'b1);
               state_ff <= S_RESP;
            end
            S_RD_WAIT: state_ff <= S_RD_TAKE;
            S_RD_TAKE: begin
               rd_ff <= OUT_W'(rdata);
               state_ff <= S_RESP;
            end
            S_RESP: if (rsp_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// Self-checking testbench for blocked_positional_insert_store.
// Depends on bpis_pkg, bpis_if and the block itself; directed rows then random
// reads/inserts, checked against fixed values or an in-bench model of the block directory.
`timescale 1ns / 1ps
module tb_top;
   import bpis_pkg::*;

   localparam int unsigned NBLK  = 16;
   localparam int unsigned SLOTS = 16;
   localparam int unsigned LIMIT_CYCLES = 400000;
   localparam int unsigned N_RANDOM = 630;

   typedef struct packed {
      logic                    req_type;
      logic [POS_W-1:0]        position;
      logic signed [31:0]      value;
   } req_beat_t;

   typedef struct packed {
      logic signed [31:0]      read_data;
      logic [1:0]              status;
      logic [POS_W-1:0]        total_after;
   } rsp_beat_t;

   typedef struct {
      logic                    req_type;
      logic [POS_W-1:0]        position;
      logic [31:0]             value;
      bit                      typed;
      logic [31:0]             read_data;
      status_type              status;
      logic [POS_W-1:0]        total_after;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   bpis_if #(.payload_type(req_beat_t)) req_ch (clock);
   bpis_if #(.payload_type(rsp_beat_t)) rsp_ch (clock);

   blocked_positional_insert_store i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_req_type    (req_ch.payload.req_type),
      .req_position    (req_ch.payload.position),
      .req_value       (req_ch.payload.value),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_read_data   (rsp_ch.payload.read_data),
      .rsp_status      (rsp_ch.payload.status),
      .rsp_total_after (rsp_ch.payload.total_after)
   );

   // directory model
   logic [31:0] elem_mem [NBLK][SLOTS];
   int unsigned blk_len [NBLK];
   int unsigned blk_order [NBLK];
   int unsigned blks_used;
   int unsigned elem_total;

   rsp_beat_t expected_rsps[$];
   int unsigned errors = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned cycles = 0;

   task automatic find_slot(input int unsigned pos, output int unsigned lblk,
                            output int unsigned off);
      int unsigned run;
      run = 0;
      lblk = blks_used - 1;
      off = blk_len[blk_order[blks_used - 1]];
      if (pos < elem_total) begin
         for (int unsigned j = 0; j < blks_used; j++) begin
            if (pos < run + blk_len[blk_order[j]]) begin
               lblk = j;
               off = pos - run;
               return;
            end
            run += blk_len[blk_order[j]];
         end
      end
   endtask

   task automatic apply_request(input req_beat_t rq, output rsp_beat_t rs);
      int unsigned lb, off, pb, len, nb, keep, moved;
      rs = '0;
      rs.status = STATUS_OK;
      if (rq.req_type == REQ_READ) begin
         if (rq.position >= elem_total || blks_used == 0) begin
            rs.status = STATUS_POS;
         end else begin
            find_slot(rq.position, lb, off);
            rs.read_data = elem_mem[blk_order[lb]][off];
         end
      end else if (rq.position > elem_total) begin
         rs.status = STATUS_POS;
      end else if (blks_used == 0) begin
         if (rq.position != 0) begin
            rs.status = STATUS_POS;
         end else begin
            pb = blk_order[0];
            elem_mem[pb][0] = rq.value;
            blk_len[pb] = 1;
            blks_used = 1;
            elem_total = 1;
         end
      end else begin
         find_slot(rq.position, lb, off);
         pb = blk_order[lb];
         len = blk_len[pb];
         if (len > SLOTS - 1) begin
            if (blks_used >= NBLK) begin
               rs.status = STATUS_FULL;
            end else begin
               // split: lower half stays, upper half goes to the next free block
               nb = blk_order[blks_used];
               keep = len / 2;
               moved = len - keep;
               for (int unsigned k = 0; k < moved; k++)
                  elem_mem[nb][k] = elem_mem[pb][keep + k];
               blk_len[pb] = keep;
               blk_len[nb] = moved;
               for (int unsigned k = blks_used; k > lb + 1; k--)
                  blk_order[k] = blk_order[k - 1];
               blk_order[lb + 1] = nb;
               blks_used++;
               find_slot(rq.position, lb, off);
               pb = blk_order[lb];
               len = blk_len[pb];
            end
         end
         if (rs.status == STATUS_OK && len < SLOTS && off <= len) begin
            for (int unsigned k = len; k > off; k--)
               elem_mem[pb][k] = elem_mem[pb][k - 1];
            elem_mem[pb][off] = rq.value;
            blk_len[pb] = len + 1;
            elem_total++;
         end
      end
      rs.total_after = elem_total[POS_W-1:0];
   endtask

   // drive one beat and hold it until taken
   task automatic send_beat(input req_beat_t rq, input bit typed, input rsp_beat_t typed_rsp);
      rsp_beat_t pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= rq;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      apply_request(rq, pred);
      expected_rsps.push_back(typed ? typed_rsp : pred);
   endtask

   task automatic drain_wait();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
   endtask

   // response side: random backpressure and in-order compare
   always @(posedge clock) begin
      rsp_beat_t want;
      cycles <= cycles + 1;
      if (!reset) rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected beat %p", $time, rsp_ch.payload);
            errors++;
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_ch.payload.read_data !== want.read_data) begin
               $display("%0t: read_data exp %h got %h", $time, want.read_data,
                        rsp_ch.payload.read_data);
               errors++;
            end
            if (rsp_ch.payload.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status,
                        rsp_ch.payload.status);
               errors++;
            end
            if (rsp_ch.payload.total_after !== want.total_after) begin
               $display("%0t: total_after exp %0d got %0d", $time, want.total_after,
                        rsp_ch.payload.total_after);
               errors++;
            end
         end
      end
      if (cycles > LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   stim_row_t dir_rows[$];

   function automatic stim_row_t mk(logic rt, int unsigned pos, logic [31:0] val, bit typed,
                                    logic [31:0] rd, status_type st, int unsigned tot);
      stim_row_t r;
      r.req_type = rt;
      r.position = pos[POS_W-1:0];
      r.value = val;
      r.typed = typed;
      r.read_data = rd;
      r.status = st;
      r.total_after = tot[POS_W-1:0];
      return r;
   endfunction

   initial begin
      req_beat_t rq;
      rsp_beat_t trsp;
      int unsigned sel;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      for (int unsigned j = 0; j < NBLK; j++) begin
         blk_len[j] = 0;
         blk_order[j] = j;
      end
      blks_used = 0;
      elem_total = 0;

      // read past end on empty store, insert away from zero with no block
      dir_rows.push_back(mk(REQ_READ, 0, 32'h0, 1, 32'h0, STATUS_POS, 0));
      dir_rows.push_back(mk(REQ_INSERT, 1, 32'h1234, 1, 32'h0, STATUS_POS, 0));
      dir_rows.push_back(mk(REQ_INSERT, 0, 32'h7fff_ffff, 1, 32'h0, STATUS_OK, 1));
      dir_rows.push_back(mk(REQ_INSERT, 0, 32'h8000_0000, 1, 32'h0, STATUS_OK, 2));
      dir_rows.push_back(mk(REQ_INSERT, 2, 32'hffff_ffff, 1, 32'h0, STATUS_OK, 3));
      dir_rows.push_back(mk(REQ_READ, 0, 32'h5555_aaaa, 1, 32'h8000_0000, STATUS_OK, 3));
      dir_rows.push_back(mk(REQ_READ, 2, 32'h0, 1, 32'hffff_ffff, STATUS_OK, 3));
      dir_rows.push_back(mk(REQ_READ, 3, 32'h0, 1, 32'h0, STATUS_POS, 3));
      dir_rows.push_back(mk(REQ_INSERT, 511, 32'h0, 1, 32'h0, STATUS_POS, 3));
      dir_rows.push_back(mk(REQ_READ, 511, 32'h0, 1, 32'h0, STATUS_POS, 3));
      dir_rows.push_back(mk(REQ_INSERT, 4, 32'h0, 1, 32'h0, STATUS_POS, 3));
      // fill the first block and push past it to force a split
      for (int unsigned k = 0; k < 14; k++)
         dir_rows.push_back(mk(REQ_INSERT, 1, 32'h100 + k, 0, 0, STATUS_OK, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 29;
      recv_idle_pct = 72;
      foreach (dir_rows[i]) begin
         rq.req_type = dir_rows[i].req_type;
         rq.position = dir_rows[i].position;
         rq.value = dir_rows[i].value;
         trsp.read_data = dir_rows[i].read_data;
         trsp.status = dir_rows[i].status;
         trsp.total_after = dir_rows[i].total_after;
         send_beat(rq, dir_rows[i].typed, trsp);
      end

      for (int unsigned ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            send_idle_pct = 72;
            recv_idle_pct = 29;
         end else if (ph == 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // hold off until all outstanding responses are back
         drain_wait();
         for (int unsigned n = 0; n < N_RANDOM / 3; n++) begin
            sel = $urandom_range(99);
            rq.value = $urandom;
            if (sel < 60) begin
               rq.req_type = REQ_INSERT;
               rq.position = ($urandom_range(3) == 0) ? elem_total[POS_W-1:0] :
                             POS_W'($urandom_range(elem_total, 0));
            end else if (sel < 85) begin
               rq.req_type = REQ_READ;
               rq.position = (elem_total == 0) ? '0 :
                             POS_W'($urandom_range(elem_total - 1, 0));
            end else begin
               rq.req_type = 1'($urandom_range(1));
               rq.position = POS_W'($urandom_range(511));
            end
            send_beat(rq, 0, trsp);
         end
      end

      drain_wait();
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule

// File: sim.f
rtl/bpis_pkg.sv
rtl/bpis_if.sv
rtl/bpis_ram.sv
rtl/blocked_positional_insert_store.sv
dv/tb_top.sv
